@@ sv/assert_macros.svh @@
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on aclk, switched off while aresetn is low.
`define CBUH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Concurrent assertion sampled on aclk that also holds during reset.
`define CBUH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ sv/cbuh_pkg.sv @@
// Package with the types and constants of the complex byte unpacker with histograms.
package cbuh_pkg;

    localparam int COUNT_W   = 32;
    localparam int VALUE_W   = 25;
    localparam int SCALE_W   = 16;
    localparam int CCOUNT_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 96;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic OP_UNPACK = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TWO_POL    = 2'd2;

    localparam logic [SCALE_W-1:0]  SCALE_RESET      = 16'd32768;
    localparam logic [CCOUNT_W-1:0] CHAN_COUNT_RESET = 5'd16;

    typedef struct packed {
        logic en;
        logic clr;
    } hist_wr_t;

endpackage

@@ sv/cbuh_hist_bank.sv @@
// One histogram memory with registered read, saturating update and write forwarding.
module cbuh_hist_bank #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    input  cbuh_pkg::hist_wr_t           wr,
    input  logic [AW-1:0]                clr_addr,
    output logic [cbuh_pkg::COUNT_W-1:0] count
);
    import cbuh_pkg::*;

    logic [COUNT_W-1:0] hist_mem [DEPTH];
    logic [COUNT_W-1:0] rd_data_reg;
    logic [AW-1:0]      addr_q_reg;
    logic               lw_valid_reg;
    logic [AW-1:0]      lw_addr_reg;
    logic [COUNT_W-1:0] lw_data_reg;
    logic [AW-1:0]      wr_addr;
    logic [COUNT_W-1:0] wr_data;

    // The most recent write wins over the registered read of the same entry.
    assign count   = (lw_valid_reg && lw_addr_reg == addr_q_reg) ? lw_data_reg : rd_data_reg;
    assign wr_addr = wr.clr ? clr_addr : addr_q_reg;
    assign wr_data = wr.clr ? '0 : ((count == COUNT_MAX) ? count : count + 1'b1);

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            hist_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= hist_mem[rd_addr];
            addr_q_reg  <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_valid_reg <= 1'b0;
        end else if (wr.en) begin
            lw_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            lw_addr_reg <= wr_addr;
            lw_data_reg <= wr_data;
        end
    end

endmodule

@@ sv/complex_byte_unpack_histogram.sv @@
// Top level of the complex 8-bit sample unpacker with per-digitizer histograms.
//
// Input beats on s_* carry one operation each: s_tuser selects unpacking a sample
// word or reading one histogram bin. Every input beat yields exactly one result
// beat on m_*, in order. Unpacking scales both parts to (2x+1)*scale and tags the
// sample with its sample, channel and polarization position, which advance per
// unpacked word; it also counts both parts in their saturating 32-bit histograms.
// Configuration is written through the cfg_* channel, which is always ready. Each
// beat is registered in the working stage, then in the output register. Unless
// stalled, the block takes one beat per cycle: each part has its own histogram
// memory with one read and one write port per cycle, and a read-modify-write
// forwards the last write. After reset both memories are swept to zero, one entry
// of each per cycle, over all MAX_CHANNELS*512 entries (8192 at the defaults);
// s_tready stays low meanwhile. On a stall the result waits in the output register
// and one more beat waits in the working stage; only then does s_tready drop.
module complex_byte_unpack_histogram #(
    parameter int MAX_CHANNELS     = 16,
    parameter int SAMPLES_PER_HEAP = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cbuh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbuh_pkg::SCALE_W-1:0]    cfg_data,
    // Input: tdata = sample_word[15:0], digitizer[21:16], bin_index[29:22], zero fill.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cbuh_pkg::S_DATA_W-1:0]   s_tdata,
    // Input: tuser = op.
    input  logic                            s_tuser,
    // Output: tdata = real_value[24:0], imag_value[49:25], channel_index[53:50],
    // polarization_index[54], sample_in_heap[62:55], bin_count[94:63], zero fill.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cbuh_pkg::M_DATA_W-1:0]   m_tdata
);
    import cbuh_pkg::*;

    localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SW    = (SAMPLES_PER_HEAP > 1) ? $clog2(SAMPLES_PER_HEAP) : 1;
    localparam int DEPTH = MAX_CHANNELS * 512;
    localparam int AW    = $clog2(DEPTH);

    logic [SCALE_W-1:0]  scale_reg;
    logic [CCOUNT_W-1:0] chan_count_reg;
    logic                two_pol_reg;

    logic [SW-1:0] spos_reg, spos_next;
    logic [CW-1:0] cpos_reg, cpos_next;
    logic          ppos_reg, ppos_next;
    logic [CW:0]   nchan_eff;

    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    logic          s1_valid_reg;
    logic          s1_op_reg;
    logic [7:0]    s1_re_reg;
    logic [7:0]    s1_im_reg;
    logic [3:0]    s1_chan_reg;
    logic          s1_pol_reg;
    logic [7:0]    s1_samp_reg;
    logic          s1_part_reg;
    logic          s1_in_range_reg;

    logic                 out_valid_reg;
    logic [M_DATA_W-1:0]  out_data_reg;
    logic [M_DATA_W-1:0]  out_data_next;

    logic          s_accept;
    logic          s1_go;
    logic [7:0]    in_re;
    logic [7:0]    in_im;
    logic [5:0]    in_dig;
    logic [7:0]    in_bin;
    logic [31:0]   re_addr_full;
    logic [31:0]   im_addr_full;
    logic [31:0]   rd_addr_full;
    logic [AW-1:0] re_addr;
    logic [AW-1:0] im_addr;
    logic [AW-1:0] rd_addr;
    hist_wr_t      hist_wr;
    logic [COUNT_W-1:0] cnt_re;
    logic [COUNT_W-1:0] cnt_im;

    logic signed [8:0]  re9;
    logic signed [8:0]  im9;
    logic signed [16:0] scale17;
    logic signed [25:0] re_prod;
    logic signed [25:0] im_prod;
    logic [COUNT_W-1:0] bin_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg      <= SCALE_RESET;
            chan_count_reg <= CHAN_COUNT_RESET;
            two_pol_reg    <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SCALE:      scale_reg      <= cfg_data;
                REG_CHAN_COUNT: chan_count_reg <= cfg_data[CCOUNT_W-1:0];
                REG_TWO_POL:    two_pol_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign s1_go    = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !clr_active_reg && (!s1_valid_reg || s1_go);
    assign s_accept = s_tvalid && s_tready;

    assign in_re  = s_tdata[7:0];
    assign in_im  = s_tdata[15:8];
    assign in_dig = s_tdata[21:16];
    assign in_bin = s_tdata[29:22];

    always_comb begin
        if (chan_count_reg == '0) begin
            nchan_eff = (CW+1)'(1);
        end else if (32'(chan_count_reg) > 32'(MAX_CHANNELS)) begin
            nchan_eff = (CW+1)'(MAX_CHANNELS);
        end else begin
            nchan_eff = (CW+1)'(chan_count_reg);
        end
    end

    always_comb begin
        spos_next = spos_reg;
        cpos_next = cpos_reg;
        ppos_next = ppos_reg;
        if (s_accept && s_tuser == OP_UNPACK) begin
            if ((SW+1)'(spos_reg) + 1'b1 >= (SW+1)'(SAMPLES_PER_HEAP)) begin
                spos_next = '0;
                if ((CW+1)'(cpos_reg) + 1'b1 >= nchan_eff) begin
                    cpos_next = '0;
                    ppos_next = two_pol_reg ? ~ppos_reg : 1'b0;
                end else begin
                    cpos_next = cpos_reg + 1'b1;
                end
            end else begin
                spos_next = spos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spos_reg <= '0;
            cpos_reg <= '0;
            ppos_reg <= 1'b0;
        end else begin
            spos_reg <= spos_next;
            cpos_reg <= cpos_next;
            ppos_reg <= ppos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    assign re_addr_full = 32'({cpos_reg, ppos_reg, in_re ^ 8'h80});
    assign im_addr_full = 32'({cpos_reg, ppos_reg, in_im ^ 8'h80});
    assign rd_addr_full = 32'({in_dig[5:1], in_bin});

    always_comb begin
        if (s_tuser == OP_READ) begin
            re_addr = rd_addr_full[AW-1:0];
            im_addr = rd_addr_full[AW-1:0];
        end else begin
            re_addr = re_addr_full[AW-1:0];
            im_addr = im_addr_full[AW-1:0];
        end
    end
    assign rd_addr = rd_addr_full[AW-1:0];

    assign hist_wr.en  = clr_active_reg || (s1_go && s1_op_reg == OP_UNPACK);
    assign hist_wr.clr = clr_active_reg;

    cbuh_hist_bank #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bank_re (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_accept),
        .rd_addr  (re_addr),
        .wr       (hist_wr),
        .clr_addr (clr_addr_reg),
        .count    (cnt_re)
    );

    cbuh_hist_bank #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bank_im (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_accept),
        .rd_addr  ((s_tuser == OP_READ) ? rd_addr : im_addr),
        .wr       (hist_wr),
        .clr_addr (clr_addr_reg),
        .count    (cnt_im)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_go) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_op_reg       <= s_tuser;
            s1_re_reg       <= in_re;
            s1_im_reg       <= in_im;
            s1_chan_reg     <= 4'(cpos_reg);
            s1_pol_reg      <= ppos_reg;
            s1_samp_reg     <= 8'(spos_reg);
            s1_part_reg     <= in_dig[0];
            s1_in_range_reg <= 32'(in_dig[5:2]) < 32'(MAX_CHANNELS);
        end
    end

    assign re9     = {s1_re_reg, 1'b1};
    assign im9     = {s1_im_reg, 1'b1};
    assign scale17 = {1'b0, scale_reg};
    assign re_prod = re9 * scale17;
    assign im_prod = im9 * scale17;

    always_comb begin
        if (!s1_in_range_reg) begin
            bin_count = '0;
        end else if (s1_part_reg) begin
            bin_count = cnt_im;
        end else begin
            bin_count = cnt_re;
        end
    end

    always_comb begin
        if (s1_op_reg == OP_READ) begin
            out_data_next = {1'b0, bin_count, 63'd0};
        end else begin
            out_data_next = {1'b0, {COUNT_W{1'b0}}, s1_samp_reg, s1_pol_reg, s1_chan_reg,
                             im_prod[VALUE_W-1:0], re_prod[VALUE_W-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_go) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ sv/cbuh_checker.sv @@
// Port-level checker for the complex byte unpacker with histograms, and its bind.
`include "assert_macros.svh"

module cbuh_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [cbuh_pkg::M_DATA_W-1:0]   m_tdata
);

    // A stalled result beat keeps its payload.
    `CBUH_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "beat changed")

    // The memory sweep after reset keeps the input closed.
    `CBUH_ASSERT(a_clear_after_reset, $rose(aresetn) |-> !s_tready, "input ready during sweep")

    // A result carries either a bin count or sample fields, never both.
    `CBUH_ASSERT(a_result_kind, m_tvalid |-> (m_tdata[94:63] == '0 || m_tdata[62:0] == '0), "mixed")

    // The fill bit of the result beat is always zero.
    `CBUH_ASSERT_ALWAYS(a_out_fill, m_tvalid == 1'b1 |-> m_tdata[95] == 1'b0, "fill bit set")

endmodule

bind complex_byte_unpack_histogram cbuh_checker u_cbuh_checker (.*);
